@@ hw/rtl/oer_pkg.sv @@
// ----------------------------------------------------------------------------
// oer_pkg
// Shared types, constants and helpers of the overwriting event ring.
// ----------------------------------------------------------------------------
package oer_pkg;

  // ring geometry
  localparam int unsigned RingDepth = 256;
  localparam int unsigned IdxW      = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned CntW      = $clog2(RingDepth + 1);

  // read request limits
  localparam int unsigned MaxRead = 64;
  localparam int unsigned ReadW   = 7;
  localparam int unsigned CmpW    = (CntW > ReadW) ? CntW : ReadW;

  // command queue between front and back
  localparam int unsigned CmdQDepth = 2;
  localparam int unsigned QPtrW     = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int unsigned QCntW     = $clog2(CmdQDepth + 1);

  // region decode constants
  localparam logic [31:0] RegionImage     = 32'h0100_0000;
  localparam logic [31:0] RegionCommitted = 32'h0000_1000;
  localparam logic [7:0]  ProtExec        = 8'h10;
  localparam logic [7:0]  ProtExecRead    = 8'h20;
  localparam logic [7:0]  ProtExecRw      = 8'h40;
  localparam logic [7:0]  ProtExecWc      = 8'h80;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_READ  = 2'd1,
    OP_EXIT  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ENTRY    = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ZERO_MAX = 2'd2
  } status_e;

  typedef enum logic {
    CMD_EVENT = 1'b0,
    CMD_READ  = 1'b1
  } cmd_kind_e;

  typedef enum logic {
    BK_IDLE    = 1'b0,
    BK_RD_DATA = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [31:0] sequence_res;
    logic        alert;
    logic        error;
    logic [31:0] process_id;
    logic [31:0] thread_id;
    logic [63:0] start_address;
    logic [31:0] mem_type;
    logic [31:0] mem_protect;
    logic [31:0] mem_state;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    cmd_kind_e          kind;
    logic [ReadW-1:0]   want;
    entry_t             entry;
  } cmd_t;

  typedef struct packed {
    status_e status;
    entry_t  entry;
    logic    last;
  } out_item_t;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] i);
    return (i == IdxW'(RingDepth - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic exec_kind(input logic [31:0] prot);
    logic [7:0] b;
    b = prot[7:0];
    return (b == ProtExec) || (b == ProtExecRead) || (b == ProtExecRw) || (b == ProtExecWc);
  endfunction

endpackage

@@ hw/rtl/oer_in_if.sv @@
// ----------------------------------------------------------------------------
// oer_in_if
// Request channel: thread-create events, read requests and thread exits.
// ----------------------------------------------------------------------------
interface oer_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] process_id;
  logic [31:0] thread_id;
  logic [63:0] start_address;
  logic [31:0] mem_type;
  logic [31:0] mem_protect;
  logic [31:0] mem_state;
  logic        query_failed;
  logic [6:0]  read_max;

  modport source (
    output valid, opcode, process_id, thread_id, start_address,
           mem_type, mem_protect, mem_state, query_failed, read_max,
    input  ready
  );

  modport sink (
    input  valid, opcode, process_id, thread_id, start_address,
           mem_type, mem_protect, mem_state, query_failed, read_max,
    output ready
  );
endinterface

@@ hw/rtl/oer_out_if.sv @@
// ----------------------------------------------------------------------------
// oer_out_if
// Result channel: recorded entries and read status.
// ----------------------------------------------------------------------------
interface oer_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] sequence_res;
  logic        alert;
  logic        error;
  logic [31:0] process_id_out;
  logic [31:0] thread_id_out;
  logic [63:0] start_address_out;
  logic [31:0] mem_type_out;
  logic [31:0] mem_protect_out;
  logic [31:0] mem_state_out;
  logic        last;

  modport source (
    output valid, status, sequence_res, alert, error, process_id_out, thread_id_out,
           start_address_out, mem_type_out, mem_protect_out, mem_state_out, last,
    input  ready
  );

  modport sink (
    input  valid, status, sequence_res, alert, error, process_id_out, thread_id_out,
           start_address_out, mem_type_out, mem_protect_out, mem_state_out, last,
    output ready
  );
endinterface

@@ hw/rtl/oer_ram.sv @@
// ----------------------------------------------------------------------------
// oer_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oer_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hw/rtl/oer_front.sv @@
// ----------------------------------------------------------------------------
// oer_front
// Accepts requests, drops thread exits, and classifies events (error, alert)
// and read sizes before they enter the command queue.
// ----------------------------------------------------------------------------
module oer_front (
  oer_in_if.sink         in_i,
  input  logic           q_full_i,
  output logic           push_o,
  output oer_pkg::cmd_t  cmd_o
);
  logic err;
  logic alert;
  logic acc;

  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && in_i.ready;

  assign err   = in_i.query_failed || (in_i.start_address == 64'd0);
  assign alert = !err && (in_i.mem_state == oer_pkg::RegionCommitted) &&
                 (in_i.mem_type != oer_pkg::RegionImage) &&
                 oer_pkg::exec_kind(in_i.mem_protect);

  always_comb begin
    cmd_o      = '0;
    push_o     = 1'b0;
    unique case (oer_pkg::opcode_e'(in_i.opcode))
      oer_pkg::OP_EVENT: begin
        push_o     = acc;
        cmd_o.kind = oer_pkg::CMD_EVENT;
      end
      oer_pkg::OP_READ: begin
        push_o     = acc;
        cmd_o.kind = oer_pkg::CMD_READ;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
    // larger requests are capped at the read limit
    cmd_o.want = (in_i.read_max > oer_pkg::ReadW'(oer_pkg::MaxRead)) ?
                 oer_pkg::ReadW'(oer_pkg::MaxRead) : in_i.read_max;
    cmd_o.entry.process_id    = in_i.process_id;
    cmd_o.entry.thread_id     = in_i.thread_id;
    cmd_o.entry.start_address = in_i.start_address;
    cmd_o.entry.error         = err;
    cmd_o.entry.alert         = alert;
    cmd_o.entry.mem_type      = err ? 32'd0 : in_i.mem_type;
    cmd_o.entry.mem_protect   = err ? 32'd0 : in_i.mem_protect;
    cmd_o.entry.mem_state     = err ? 32'd0 : in_i.mem_state;
  end
endmodule

@@ hw/rtl/oer_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// oer_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module oer_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  oer_pkg::cmd_t  cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output oer_pkg::cmd_t  cmd_o,
  input  logic           pop_i
);
  oer_pkg::cmd_t                slot_q [oer_pkg::CmdQDepth];
  logic [oer_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [oer_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [oer_pkg::QCntW-1:0]    cnt_q, cnt_d;
  logic                         do_push;
  logic                         do_pop;

  function automatic logic [oer_pkg::QPtrW-1:0] ptr_inc(input logic [oer_pkg::QPtrW-1:0] p);
    return (p == oer_pkg::QPtrW'(oer_pkg::CmdQDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == oer_pkg::QCntW'(oer_pkg::CmdQDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end
endmodule

@@ hw/rtl/oer_back.sv @@
// ----------------------------------------------------------------------------
// oer_back
// Ring state and entry memory: writes events, answers reads with a status
// or streams entries oldest first through an output register.
// ----------------------------------------------------------------------------
module oer_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  oer_pkg::cmd_t       cmd_i,
  output logic                pop_o,
  oer_out_if.source           out_o
);
  oer_pkg::back_state_e          state_q, state_d;
  logic [oer_pkg::IdxW-1:0]      widx_q, widx_d;
  logic [oer_pkg::IdxW-1:0]      ridx_q, ridx_d;
  logic [oer_pkg::CntW-1:0]      fill_q, fill_d;
  logic [31:0]                   seq_q, seq_d;
  logic [oer_pkg::ReadW-1:0]     rem_q, rem_d;
  logic                          out_valid_q, out_valid_d;
  oer_pkg::out_item_t            out_q, out_d;

  logic                          ram_we;
  logic                          ram_re;
  logic [oer_pkg::IdxW-1:0]      ram_raddr;
  oer_pkg::entry_t               ram_wdata;
  logic [oer_pkg::EntryW-1:0]    ram_rdata;
  logic                          out_free;
  logic                          ring_full;

  oer_ram #(
    .Width (oer_pkg::EntryW),
    .Depth (oer_pkg::RingDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign ring_full = (fill_q == oer_pkg::CntW'(oer_pkg::RingDepth));

  always_comb begin
    state_d     = state_q;
    widx_d      = widx_q;
    ridx_d      = ridx_q;
    fill_d      = fill_q;
    seq_d       = seq_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = ridx_q;
    ram_wdata   = cmd_i.entry;
    ram_wdata.sequence_res = seq_q + 32'd1;

    unique case (state_q)
      oer_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            oer_pkg::CMD_EVENT: begin
              pop_o  = 1'b1;
              ram_we = 1'b1;
              seq_d  = seq_q + 32'd1;
              widx_d = oer_pkg::next_slot(widx_q);
              // full ring drops the oldest entry
              if (ring_full) begin
                ridx_d = oer_pkg::next_slot(ridx_q);
              end else begin
                fill_d = fill_q + 1'b1;
              end
            end
            oer_pkg::CMD_READ: begin
              if (cmd_i.want == '0 || fill_q == '0) begin
                if (out_free) begin
                  pop_o        = 1'b1;
                  out_valid_d  = 1'b1;
                  out_d        = '0;
                  out_d.status = (cmd_i.want == '0) ? oer_pkg::ST_ZERO_MAX
                                                    : oer_pkg::ST_EMPTY;
                  out_d.last   = 1'b1;
                end
              end else begin
                pop_o   = 1'b1;
                ram_re  = 1'b1;
                state_d = oer_pkg::BK_RD_DATA;
                if (oer_pkg::CmpW'(fill_q) < oer_pkg::CmpW'(cmd_i.want)) begin
                  rem_d = oer_pkg::ReadW'(fill_q);
                end else begin
                  rem_d = cmd_i.want;
                end
              end
            end
            default: begin
              pop_o = 1'b0;
            end
          endcase
        end
      end
      oer_pkg::BK_RD_DATA: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.status = oer_pkg::ST_ENTRY;
          out_d.entry  = oer_pkg::entry_t'(ram_rdata);
          out_d.last   = (rem_q == oer_pkg::ReadW'(1));
          ridx_d       = oer_pkg::next_slot(ridx_q);
          fill_d       = fill_q - 1'b1;
          rem_d        = rem_q - 1'b1;
          if (rem_q == oer_pkg::ReadW'(1)) begin
            state_d = oer_pkg::BK_IDLE;
          end else begin
            // fetch the next entry behind the one being handed out
            ram_re    = 1'b1;
            ram_raddr = oer_pkg::next_slot(ridx_q);
          end
        end
      end
      default: begin
        state_d = oer_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oer_pkg::BK_IDLE;
      widx_q      <= '0;
      ridx_q      <= '0;
      fill_q      <= '0;
      seq_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      widx_q      <= widx_d;
      ridx_q      <= ridx_d;
      fill_q      <= fill_d;
      seq_q       <= seq_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = out_q.status;
  assign out_o.sequence_res      = out_q.entry.sequence_res;
  assign out_o.alert             = out_q.entry.alert;
  assign out_o.error             = out_q.entry.error;
  assign out_o.process_id_out    = out_q.entry.process_id;
  assign out_o.thread_id_out     = out_q.entry.thread_id;
  assign out_o.start_address_out = out_q.entry.start_address;
  assign out_o.mem_type_out      = out_q.entry.mem_type;
  assign out_o.mem_protect_out   = out_q.entry.mem_protect;
  assign out_o.mem_state_out     = out_q.entry.mem_state;
  assign out_o.last              = out_q.last;
endmodule

@@ hw/rtl/overwriting_event_ring.sv @@
// ----------------------------------------------------------------------------
// overwriting_event_ring
// Event recorder on a circular buffer that overwrites its oldest entry.
//
//   port    | dir | carries
//   --------+-----+------------------------------------------------------
//   in_i    | in  | opcode, event fields, query_failed, read_max
//   out_o   | out | status, recorded entry fields, last
//
// An event is written into the entry RAM in the cycle it leaves the
// command queue; an event or read enters the queue in the cycle it is taken.
// A read with entries streams one entry per cycle from the single RAM read
// port while out_o is ready, after a first RAM access as it leaves the queue.
// Status results and events are each handled in the back end's idle state.
// After reset the ring is empty and the sequence count restarts at 1.
// A stall on out_o holds back-end reads; in_i keeps filling the two-deep queue.
// ----------------------------------------------------------------------------
module overwriting_event_ring (
  input  logic       clk_i,
  input  logic       rst_ni,
  oer_in_if.sink     in_i,
  oer_out_if.source  out_o
);
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  oer_pkg::cmd_t  push_cmd;
  oer_pkg::cmd_t  head_cmd;

  oer_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  oer_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  oer_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("command pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("command popped from an empty queue");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != oer_pkg::ST_ENTRY) |-> out_o.last)
    else $error("status result without last");
`endif
endmodule
